// File: rtl/boas_pkg.sv
package boas_pkg;
    localparam int DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int OP_W = 3;
    localparam int IDX_W = 16;
    localparam int VAL_W = 64;
    localparam int ST_W = 2;
    localparam int POS_W = 9;

    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [OP_W-1:0] OP_SIZE   = 3'd6;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd7;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] data;
        logic [POS_W-1:0] position;
    } t_rsp;
endpackage

// File: rtl/boas_if.sv
interface boas_cmd_if;
    logic            valid;
    logic            ready;
    boas_pkg::t_cmd  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface boas_rsp_if;
    logic            valid;
    logic            ready;
    boas_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/boas_front.sv
// Accepts requests into a two-entry queue towards the back end.
module boas_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    boas_cmd_if.sink      i_cmd,
    output logic          o_q_valid,
    output boas_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    boas_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push = i_cmd.valid && i_cmd.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd.payload;
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: rtl/boas_back.sv
// Executes commands against the element memory, one memory access at a time.
module boas_back #(
    parameter int DEPTH = boas_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = boas_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  boas_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    boas_rsp_if.source     o_rsp
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_USE  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [2:0] r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_end, n_end;
    logic [boas_pkg::OP_W-1:0] r_op, n_op;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    boas_pkg::t_rsp r_rsp, n_rsp;
    boas_pkg::t_rsp r_orsp, n_orsp;
    logic r_ovalid, n_ovalid;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic rd_en;
    logic [boas_pkg::IDX_W-1:0] idx;
    logic idx_lt, idx_le;

    assign idx = i_q_cmd.index;
    assign idx_lt = {{(boas_pkg::IDX_W+1-CW){1'b0}}, r_count} > {1'b0, idx};
    assign idx_le = {{(boas_pkg::IDX_W+1-CW){1'b0}}, r_count} >= {1'b0, idx};
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_orsp;

    // Element memory with registered read.
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (rd_en) r_rdata <= r_mem[raddr];
    end

    // Command sequencer.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr = r_ptr;
        n_end = r_end;
        n_op = r_op;
        n_word = r_word;
        n_rsp = r_rsp;
        n_orsp = r_orsp;
        n_ovalid = r_ovalid;
        o_q_pop = 1'b0;
        we = 1'b0;
        waddr = r_ptr[AW-1:0];
        wdata = r_word;
        rd_en = 1'b0;
        raddr = r_ptr[AW-1:0];
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op = i_q_cmd.operation;
                    n_word = i_q_cmd.value[DATA_WIDTH-1:0];
                    n_rsp = '{status: boas_pkg::ST_DONE, data: '0, position: '0};
                    n_state = S_OUT;
                    unique case (i_q_cmd.operation)
                        boas_pkg::OP_GET: begin
                            if (idx_lt) begin
                                rd_en = 1'b1;
                                raddr = idx[AW-1:0];
                                n_state = S_WAIT;
                            end else n_rsp.status = boas_pkg::ST_MISS;
                        end
                        boas_pkg::OP_SET: begin
                            if (idx_lt) begin
                                we = 1'b1;
                                waddr = idx[AW-1:0];
                                wdata = i_q_cmd.value[DATA_WIDTH-1:0];
                            end else n_rsp.status = boas_pkg::ST_REFUSED;
                        end
                        boas_pkg::OP_INSERT, boas_pkg::OP_APPEND: begin
                            // Shift from the top down; r_end is the insert point.
                            n_end = (i_q_cmd.operation == boas_pkg::OP_APPEND) ?
                                    r_count : idx[CW-1:0];
                            if ((i_q_cmd.operation == boas_pkg::OP_INSERT && !idx_le) ||
                                r_count == CW'(DEPTH))
                                n_rsp.status = boas_pkg::ST_REFUSED;
                            else begin
                                n_ptr = r_count;
                                n_count = r_count + 1'b1;
                                n_state = S_RD;
                            end
                        end
                        boas_pkg::OP_DELETE: begin
                            if (idx_lt) begin
                                n_ptr = idx[CW-1:0];
                                n_count = r_count - 1'b1;
                                n_end = r_count - 1'b1;
                                n_state = S_RD;
                            end else n_rsp.status = boas_pkg::ST_REFUSED;
                        end
                        boas_pkg::OP_CLEAR: n_count = '0;
                        boas_pkg::OP_SIZE: n_rsp.position = boas_pkg::POS_W'(r_count);
                        boas_pkg::OP_FIND: begin
                            n_ptr = '0;
                            n_state = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                // Issue the read for the next step, or finish.
                unique case (r_op)
                    boas_pkg::OP_FIND: begin
                        if (r_ptr == r_count) begin
                            n_rsp.position = boas_pkg::POS_W'(r_ptr);
                            n_state = S_OUT;
                        end else begin
                            rd_en = 1'b1;
                            n_state = S_WAIT;
                        end
                    end
                    boas_pkg::OP_DELETE: begin
                        if (r_ptr == r_end) n_state = S_OUT;
                        else begin
                            rd_en = 1'b1;
                            raddr = AW'(r_ptr + 1'b1);
                            n_state = S_WAIT;
                        end
                    end
                    default: begin
                        if (r_ptr == r_end) begin
                            we = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            rd_en = 1'b1;
                            raddr = AW'(r_ptr - 1'b1);
                            n_state = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: n_state = S_USE;
            S_USE: begin
                unique case (r_op)
                    boas_pkg::OP_GET: begin
                        n_rsp.data = boas_pkg::VAL_W'(r_rdata);
                        n_state = S_OUT;
                    end
                    boas_pkg::OP_FIND: begin
                        if (r_rdata == r_word) begin
                            n_rsp.position = boas_pkg::POS_W'(r_ptr);
                            n_state = S_OUT;
                        end else begin
                            n_ptr = r_ptr + 1'b1;
                            n_state = S_RD;
                        end
                    end
                    boas_pkg::OP_DELETE: begin
                        we = 1'b1;
                        wdata = r_rdata;
                        n_ptr = r_ptr + 1'b1;
                        n_state = S_RD;
                    end
                    default: begin
                        we = 1'b1;
                        wdata = r_rdata;
                        n_ptr = r_ptr - 1'b1;
                        n_state = S_RD;
                    end
                endcase
            end
            S_OUT: begin
                // Hand the finished result to the output register once it is free.
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_orsp = r_rsp;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_end <= n_end;
        r_op <= n_op;
        r_word <= n_word;
        r_rsp <= n_rsp;
        r_orsp <= n_orsp;
    end
endmodule

// File: rtl/bounded_ordered_array_store_top.sv
// Set, clear, size and any refusal or miss are answered from the command alone; a get that
// hits also waits for the registered memory read.
// Insert, append and delete move the entries one at a time, a read then a write for each;
// find reads and compares the entries in order until a match or the end of the list.
// One command is executed at a time; a two-entry queue holds further requests.
// Synchronous active-low reset empties the list; memory contents are kept.
module bounded_ordered_array_store_top #(
    parameter int DEPTH = boas_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = boas_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    boas_cmd_if.sink   i_cmd,
    boas_rsp_if.source o_rsp
);
    logic q_valid, q_pop;
    boas_pkg::t_cmd q_cmd;

    boas_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    boas_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .i_q_cmd(q_cmd), .o_q_pop(q_pop), .o_rsp(o_rsp)
    );
endmodule

// File: rtl/boas_checker.sv
// Port-level checks on the list store.
module boas_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input boas_pkg::t_rsp i_rsp
);
    // A pending response holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response changed while stalled");
    // Status is never an unused code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp.status <= boas_pkg::ST_MISS) else $error("bad status");
    // Data is zero unless the status is done.
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != boas_pkg::ST_DONE |-> i_rsp.data == '0)
        else $error("data not zero");
endmodule

bind bounded_ordered_array_store_top boas_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .i_rsp(o_rsp.payload)
);

// File: sim/bounded_ordered_array_store_top_tb.sv
module bounded_ordered_array_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = boas_pkg::DEPTH_DEF;
    localparam int RAND_REQUESTS = 220;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_ROWS = 24;
    localparam logic [boas_pkg::POS_W-1:0] NO_POS = '0;
    localparam logic [boas_pkg::VAL_W-1:0] NO_DATA = '0;
    localparam logic [boas_pkg::VAL_W-1:0] ALL_ONES = '1;

    logic i_clk;
    logic i_rst_n;

    boas_cmd_if cmd_ch();
    boas_rsp_if rsp_ch();

    bounded_ordered_array_store_top #(
        .DEPTH(LIST_DEPTH),
        .DATA_WIDTH(boas_pkg::DATA_WIDTH_DEF)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    // Shadow copy of the list held by the block.
    logic [boas_pkg::VAL_W-1:0] shadow_list [LIST_DEPTH];
    int unsigned shadow_count = 0;

    // Responses still owed by the block, oldest first.
    boas_pkg::t_rsp owed_rsp [$];
    int error_count = 0;
    int pred_errors = 0;
    int idle_cycles = 0;

    // Work out the response to one request and update the shadow list.
    function automatic boas_pkg::t_rsp apply_request(boas_pkg::t_cmd req);
        boas_pkg::t_rsp r;
        int unsigned at;
        r.status = boas_pkg::ST_DONE;
        r.data = NO_DATA;
        r.position = NO_POS;
        case (req.operation)
            boas_pkg::OP_GET: begin
                if (req.index < shadow_count) r.data = shadow_list[req.index];
                else r.status = boas_pkg::ST_MISS;
            end
            boas_pkg::OP_SET: begin
                if (req.index < shadow_count) shadow_list[req.index] = req.value;
                else r.status = boas_pkg::ST_REFUSED;
            end
            boas_pkg::OP_INSERT, boas_pkg::OP_APPEND: begin
                at = (req.operation == boas_pkg::OP_APPEND) ? shadow_count : 32'(req.index);
                if (at > shadow_count || shadow_count >= LIST_DEPTH) begin
                    r.status = boas_pkg::ST_REFUSED;
                end else begin
                    for (int i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[at] = req.value;
                    shadow_count++;
                end
            end
            boas_pkg::OP_DELETE: begin
                if (req.index < shadow_count) begin
                    for (int i = req.index + 1; i < shadow_count; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_count--;
                end else begin
                    r.status = boas_pkg::ST_REFUSED;
                end
            end
            boas_pkg::OP_CLEAR: shadow_count = 0;
            boas_pkg::OP_SIZE: r.position = shadow_count[boas_pkg::POS_W-1:0];
            default: begin
                at = 0;
                while (at < shadow_count && shadow_list[at] != req.value) at++;
                r.position = at[boas_pkg::POS_W-1:0];
            end
        endcase
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stalls on a rotating pattern, with calm stretches between.
    initial begin
        int unsigned phase;
        phase = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if ((phase / 200) % 3 == 2) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
        end
    end

    // Response check against the oldest owed response.
    always @(posedge i_clk) begin
        boas_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (owed_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, rsp_ch.payload);
                error_count++;
            end else begin
                want = owed_rsp.pop_front();
                if (rsp_ch.payload.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.payload.status);
                if (rsp_ch.payload.data !== want.data)
                    $display("%0t: data expected %h actual %h", $time,
                             want.data, rsp_ch.payload.data);
                if (rsp_ch.payload.position !== want.position)
                    $display("%0t: position expected %0d actual %0d", $time,
                             want.position, rsp_ch.payload.position);
                if (rsp_ch.payload !== want) error_count++;
            end
        end
    end

    // Watchdog on cycles without any accepted request or response.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("bounded_ordered_array_store_top_tb: done, errors");
            $finish;
        end
    end

    // Send one request, holding valid until it is taken; an optional
    // response typed by hand is checked against the prediction.
    task automatic send_request(boas_pkg::t_cmd req, bit has_known, boas_pkg::t_rsp known);
        boas_pkg::t_rsp pred;
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= req;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pred = apply_request(req);
        if (has_known && pred !== known) begin
            $display("%0t: prediction expected %h actual %h", $time, known, pred);
            pred_errors++;
        end
        owed_rsp = {owed_rsp, pred};
    endtask

    task automatic drop_valid();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic boas_pkg::t_cmd make_cmd(logic [boas_pkg::OP_W-1:0] op,
                                                logic [boas_pkg::IDX_W-1:0] idx,
                                                logic [boas_pkg::VAL_W-1:0] val);
        boas_pkg::t_cmd c;
        c.operation = op;
        c.index = idx;
        c.value = val;
        return c;
    endfunction

    function automatic boas_pkg::t_rsp make_rsp(logic [boas_pkg::ST_W-1:0] st,
                                                logic [boas_pkg::VAL_W-1:0] d,
                                                logic [boas_pkg::POS_W-1:0] p);
        boas_pkg::t_rsp r;
        r.status = st;
        r.data = d;
        r.position = p;
        return r;
    endfunction

    // Directed table: request, whether the response is known, and that response.
    typedef struct {
        boas_pkg::t_cmd req;
        bit             known;
        boas_pkg::t_rsp rsp;
    } t_row;

    t_row dir_rows [MAX_ROWS];
    int n_rows = 0;

    function automatic void add_row(boas_pkg::t_cmd req, bit known, boas_pkg::t_rsp rsp);
        dir_rows[n_rows] = '{req, known, rsp};
        n_rows++;
    endfunction

    function automatic logic [boas_pkg::VAL_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic boas_pkg::t_cmd rand_cmd();
        int unsigned pick;
        logic [boas_pkg::IDX_W-1:0] idx;
        logic [boas_pkg::VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        // Mostly legal indexes, sometimes anything at all.
        if ($urandom_range(0, 9) == 0) idx = boas_pkg::IDX_W'($urandom());
        else idx = boas_pkg::IDX_W'($urandom_range(0, shadow_count + 1));
        // Reuse stored words so that finds hit.
        if (shadow_count > 0 && $urandom_range(0, 2) == 0)
            val = shadow_list[$urandom_range(0, shadow_count - 1)];
        else
            val = rand_word();
        if (pick < 12) return make_cmd(boas_pkg::OP_GET, idx, val);
        if (pick < 22) return make_cmd(boas_pkg::OP_SET, idx, val);
        if (pick < 42) return make_cmd(boas_pkg::OP_INSERT, idx, val);
        if (pick < 62) return make_cmd(boas_pkg::OP_APPEND, idx, val);
        if (pick < 76) return make_cmd(boas_pkg::OP_DELETE, idx, val);
        if (pick < 78) return make_cmd(boas_pkg::OP_CLEAR, idx, val);
        if (pick < 86) return make_cmd(boas_pkg::OP_SIZE, idx, val);
        return make_cmd(boas_pkg::OP_FIND, idx, val);
    endfunction

    // Stimulus.
    initial begin
        int sent;
        int burst;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(make_cmd(boas_pkg::OP_SIZE, '0, '0), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_GET, '0, '0), 1,
                make_rsp(boas_pkg::ST_MISS, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_SET, '0, '1), 1,
                make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_DELETE, '0, '0), 1,
                make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_INSERT, 16'd1, '0), 1,
                make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_FIND, '0, '0), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_INSERT, '0, '1), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_APPEND, '1, '0), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_GET, '0, '0), 1,
                make_rsp(boas_pkg::ST_DONE, ALL_ONES, NO_POS));
        add_row(make_cmd(boas_pkg::OP_GET, '1, '0), 1,
                make_rsp(boas_pkg::ST_MISS, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_INSERT, 16'd1, 64'h5555_AAAA_5555_AAAA), 0,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_FIND, '1, '0), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, 9'd2));
        add_row(make_cmd(boas_pkg::OP_FIND, '0, 64'h1234), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, 9'd3));
        add_row(make_cmd(boas_pkg::OP_SET, 16'd2, 64'hAAAA_5555_AAAA_5555), 0,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_DELETE, '0, '0), 0,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_SET, '1, '0), 1,
                make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_DELETE, '1, '0), 1,
                make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_SIZE, '1, '1), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, 9'd2));
        add_row(make_cmd(boas_pkg::OP_CLEAR, '1, '1), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        add_row(make_cmd(boas_pkg::OP_SIZE, '0, '0), 1,
                make_rsp(boas_pkg::ST_DONE, NO_DATA, NO_POS));
        for (int k = 0; k < n_rows; k++)
            send_request(dir_rows[k].req, dir_rows[k].known, dir_rows[k].rsp);
        drop_valid();

        // Fill to the top, check the full list refuses, then empty it.
        for (int k = 0; k < LIST_DEPTH; k++)
            send_request(make_cmd(boas_pkg::OP_APPEND, '0, rand_word()), 0, '0);
        send_request(make_cmd(boas_pkg::OP_APPEND, '0, '1), 1,
                     make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        send_request(make_cmd(boas_pkg::OP_INSERT, '0, '1), 1,
                     make_rsp(boas_pkg::ST_REFUSED, NO_DATA, NO_POS));
        send_request(make_cmd(boas_pkg::OP_SIZE, '0, '0), 1,
                     make_rsp(boas_pkg::ST_DONE, NO_DATA, 9'd256));
        send_request(make_cmd(boas_pkg::OP_FIND, '0, shadow_list[LIST_DEPTH-1]), 0, '0);
        send_request(make_cmd(boas_pkg::OP_DELETE, '0, '0), 0, '0);
        send_request(make_cmd(boas_pkg::OP_CLEAR, '0, '0), 0, '0);
        drop_valid();

        // Random bursts with random gaps.
        sent = 0;
        while (sent < RAND_REQUESTS) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < RAND_REQUESTS; k++) begin
                send_request(rand_cmd(), 0, '0);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        drop_valid();

        while (owed_rsp.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (error_count == 0 && pred_errors == 0)
            $display("bounded_ordered_array_store_top_tb: done, clean");
        else
            $display("bounded_ordered_array_store_top_tb: done, errors");
        $finish;
    end
endmodule
